FILE: design/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/jsu_pkg.sv
// Shared types and constants for the JSON string unescape block.
// No dependencies; imported by every module of the block.
package jsu_pkg;

    localparam int RUN_BYTES   = 5;
    localparam int RIDX_W      = 3;
    localparam int CAP_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd255;

    // All results caused by one input item: up to five decoded bytes,
    // optionally followed by the end-of-string result.
    typedef struct packed {
        logic [RUN_BYTES-1:0][7:0] bytes;
        logic [RIDX_W-1:0]         nbytes;
        logic                      fin;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

FILE: design/jsu_front.sv
// Front end: accepts raw bytes, tracks the escape state and builds one run
// descriptor per item. Depends on jsu_pkg.
module jsu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_in_byte,
    input  logic               i_start_req,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    input  jsu_pkg::t_qstat    i_qstat,
    output logic               o_stall,
    output logic               o_push,
    output jsu_pkg::t_run      o_run
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_TEXT,
        MODE_ESC,
        MODE_U0,
        MODE_U1,
        MODE_U2,
        MODE_U3
    } t_mode;

    t_mode                     r_mode;
    logic [CAP_W-1:0]          r_count;
    logic [7:0]                r_esc;
    logic [2:0][7:0]           r_held;
    logic [CAP_W-1:0]          r_cap;

    t_mode                     eff_mode;
    t_mode                     tail_mode;
    t_mode                     u_next;
    t_mode                     n_mode;
    logic [CAP_W-1:0]          base_count;
    logic [CAP_W-1:0]          n_count;
    logic [CAP_W-1:0]          cnt_try;
    logic [7:0]                base_esc;
    logic [7:0]                n_esc;
    logic [2:0][7:0]           n_held;
    logic [RUN_BYTES-1:0][7:0] cand;
    logic [RIDX_W-1:0]         ncand;
    logic [RIDX_W-1:0]         cut_n;
    logic [RIDX_W-1:0]         run_n;
    logic                      run_fin;
    logic                      start_fin;
    logic                      tail_fin;
    logic                      cut;
    logic                      in_u;
    logic [1:0]                u_idx;
    logic [4:0]                nib;
    logic                      is_term;
    logic                      is_bsl;
    logic                      accept;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] res;
        res = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            res = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            res = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            res = {1'b1, 4'(b - 8'h37)};
        end
        return res;
    endfunction

    assign accept  = i_valid && !i_qstat.full;
    assign o_stall = i_qstat.full;

    always_comb begin
        eff_mode   = r_mode;
        base_count = r_count;
        base_esc   = r_esc;
        start_fin  = 1'b0;
        cand       = '0;
        ncand      = '0;
        tail_fin   = 1'b0;
        n_esc      = r_esc;
        n_held     = r_held;
        in_u       = 1'b0;
        u_idx      = '0;
        u_next     = MODE_TEXT;
        cut        = 1'b0;
        cut_n      = '0;
        cnt_try    = '0;
        nib        = hex_nibble(i_in_byte);
        is_term    = (i_in_byte == CH_NUL) || (i_in_byte == CH_QUOTE);
        is_bsl     = (i_in_byte == CH_BSLASH);

        // A start drops whatever string was in progress.
        if (i_start_req) begin
            base_count = '0;
            base_esc   = '0;
            n_esc      = '0;
            if (r_cap == '0) begin
                start_fin = 1'b1;
                eff_mode  = MODE_IDLE;
            end else begin
                eff_mode  = MODE_TEXT;
            end
        end
        tail_mode = eff_mode;

        case (eff_mode)
            MODE_TEXT: begin
                if (is_term) begin
                    tail_fin = 1'b1;
                end else if (is_bsl) begin
                    tail_mode = MODE_ESC;
                end else begin
                    cand[0] = i_in_byte;
                    ncand   = 3'd1;
                end
            end
            MODE_ESC: begin
                tail_mode = MODE_TEXT;
                if (i_in_byte == CH_NUL) begin
                    cand[0]  = CH_BSLASH;
                    ncand    = 3'd1;
                    tail_fin = 1'b1;
                end else if (i_in_byte == CH_U) begin
                    n_esc     = '0;
                    tail_mode = MODE_U0;
                end else if (i_in_byte == CH_N) begin
                    cand[0] = CH_LF;
                    ncand   = 3'd1;
                end else if (i_in_byte == CH_T) begin
                    cand[0] = CH_TAB;
                    ncand   = 3'd1;
                end else if (i_in_byte != CH_R) begin
                    cand[0] = i_in_byte;
                    ncand   = 3'd1;
                end
            end
            MODE_U0: begin
                in_u   = 1'b1;
                u_idx  = 2'd0;
                u_next = MODE_U1;
            end
            MODE_U1: begin
                in_u   = 1'b1;
                u_idx  = 2'd1;
                u_next = MODE_U2;
            end
            MODE_U2: begin
                in_u   = 1'b1;
                u_idx  = 2'd2;
                u_next = MODE_U3;
            end
            MODE_U3: begin
                in_u   = 1'b1;
                u_idx  = 2'd3;
                u_next = MODE_TEXT;
            end
            default: begin
            end
        endcase

        if (in_u) begin
            if (nib[4]) begin
                n_esc = {base_esc[3:0], nib[3:0]};
                if (u_idx == 2'd3) begin
                    tail_mode = MODE_TEXT;
                    cand[0]   = n_esc;
                    ncand     = 3'd1;
                end else begin
                    n_held[u_idx] = i_in_byte;
                    tail_mode     = u_next;
                end
            end else begin
                // Broken escape: replay 'u' and the held digits, then treat
                // the current byte as plain text.
                tail_mode = MODE_TEXT;
                cand[0]   = CH_U;
                cand[1]   = (u_idx > 2'd0) ? r_held[0] : i_in_byte;
                cand[2]   = (u_idx > 2'd1) ? r_held[1] : i_in_byte;
                cand[3]   = (u_idx > 2'd2) ? r_held[2] : i_in_byte;
                cand[4]   = i_in_byte;
                if (is_term) begin
                    ncand    = {1'b0, u_idx} + 3'd1;
                    tail_fin = 1'b1;
                end else if (is_bsl) begin
                    ncand     = {1'b0, u_idx} + 3'd1;
                    tail_mode = MODE_ESC;
                end else begin
                    ncand = {1'b0, u_idx} + 3'd2;
                end
            end
        end

        // The capacity is checked after every emitted byte; the first byte
        // that reaches it ends the string.
        for (int j = 0; j < RUN_BYTES; j++) begin
            cnt_try = base_count + CAP_W'(j + 1);
            if (!cut && (RIDX_W'(j) < ncand) && (cnt_try >= r_cap)) begin
                cut   = 1'b1;
                cut_n = RIDX_W'(j + 1);
            end
        end

        if (cut) begin
            run_n   = cut_n;
            run_fin = 1'b1;
            n_mode  = MODE_IDLE;
        end else begin
            run_n   = ncand;
            run_fin = start_fin || tail_fin;
            n_mode  = run_fin ? MODE_IDLE : tail_mode;
        end
        n_count = base_count + {{(CAP_W-RIDX_W){1'b0}}, run_n};
    end

    assign o_push = accept && ((run_n != '0) || run_fin);
    assign o_run  = '{bytes: cand, nbytes: run_n, fin: run_fin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
            r_esc   <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_mode  <= n_mode;
                r_count <= n_count;
                r_esc   <= n_esc;
                r_held  <= n_held;
            end
        end
    end

endmodule

FILE: design/jsu_queue.sv
// Short queue of run descriptors between the front and back ends.
// Depends on jsu_pkg.
module jsu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jsu_pkg::t_run    i_run,
    input  logic             i_pop,
    output jsu_pkg::t_run    o_head,
    output jsu_pkg::t_qstat  o_stat
);
    import jsu_pkg::*;

    t_run              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_run;
                r_wr        <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: design/jsu_back.sv
// Back end: walks the head run descriptor and, unless stalled, issues one
// result per cycle into the output register. Depends on jsu_pkg.
module jsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jsu_pkg::t_run    i_head,
    input  jsu_pkg::t_qstat  i_qstat,
    input  logic             i_stall,
    output logic             o_pop,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_has_byte,
    output logic             o_finished,
    output logic             o_last_of_run
);
    import jsu_pkg::*;

    logic [RIDX_W-1:0] r_idx;
    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_has;
    logic              r_fin;
    logic              r_last;

    logic [RIDX_W-1:0] total;
    logic              load;
    logic              is_byte;
    logic              is_last;
    logic [7:0]        sel_byte;

    assign total   = i_head.nbytes + {{(RIDX_W-1){1'b0}}, i_head.fin};
    assign load    = !i_qstat.empty && (!r_valid || !i_stall);
    assign is_byte = r_idx < i_head.nbytes;
    assign is_last = (r_idx == total - 1'b1);
    assign o_pop   = load && is_last;

    always_comb begin
        case (r_idx)
            3'd0:    sel_byte = i_head.bytes[0];
            3'd1:    sel_byte = i_head.bytes[1];
            3'd2:    sel_byte = i_head.bytes[2];
            3'd3:    sel_byte = i_head.bytes[3];
            3'd4:    sel_byte = i_head.bytes[4];
            default: sel_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_byte  <= is_byte ? sel_byte : 8'h00;
            r_has   <= is_byte;
            r_fin   <= !is_byte;
            r_last  <= is_last;
            r_idx   <= is_last ? '0 : r_idx + 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_has_byte    = r_has;
    assign o_finished    = r_fin;
    assign o_last_of_run = r_last;

endmodule

FILE: design/json_string_unescape.sv
// Top level of the JSON string unescape block.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Input channel: one raw byte of a JSON string body per item (i_valid,
// o_stall), with i_start_req set on the first byte after the opening quote.
// Output channel: decoded results (o_valid, i_stall); each result carries a
// byte, or the end-of-string mark, and o_last_of_run flags the final result
// caused by one input item. An item causes zero to six results.
// Configuration: i_cfg_valid / o_cfg_ready writes out_capacity, the most
// bytes emitted per string; it is always ready and reads 255 after reset.
// Data path: an accepted item's run is written to the run queue, and its
// results then pass through the output register. While the receiver does not
// stall, the back end issues one result per cycle, and items with at most one
// result flow at one per cycle. A four-entry run queue between the decoder
// and the result sequencer absorbs replay bursts of broken unicode escapes.
// Reset (synchronous, active low) empties the queue and the output register
// and leaves the decoder idle until the next start; no clearing pass runs.
// When the receiver stalls, the output result holds, the queue fills, and
// o_stall rises once it is full.
module json_string_unescape (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_start_req,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_finished,
    output logic        o_last_of_run
);
    import jsu_pkg::*;

    t_run   push_run;
    t_run   head_run;
    t_qstat qstat;
    logic   push;
    logic   pop;

    assign o_cfg_ready = 1'b1;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_byte   (i_in_byte),
        .i_start_req (i_start_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_run       (push_run)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (push_run),
        .i_pop   (pop),
        .o_head  (head_run),
        .o_stat  (qstat)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_run),
        .i_qstat       (qstat),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_has_byte    (o_has_byte),
        .o_finished    (o_finished),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: design/jsu_checker.sv
// Port-level checker for the JSON string unescape block, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_has_byte,
    input logic       o_finished,
    input logic       o_last_of_run
);

    // A stalled result must hold.
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_has_byte) && $stable(o_finished) && $stable(o_last_of_run), "stalled result changed")

    // The end-of-string result carries no byte and closes its run.
    `ASSERT_CLK(a_fin_shape, i_clk, i_rst_n, o_valid && o_finished |-> !o_has_byte && o_last_of_run && (o_out_byte == 8'h00), "bad end-of-string result")

    // Every result is either a byte or the end mark, never both or neither.
    `ASSERT_CLK(a_kind, i_clk, i_rst_n, o_valid |-> (o_has_byte != o_finished), "result is neither byte nor end")

    // Reset clears the output register.
    `ASSERT_CLK_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);
